// ===== design/scfw_pkg.sv =====
package scfw_pkg;

   // default store depth in bytes
   localparam int STORE_BYTES_DEF = 262144;

   // field widths
   localparam int CMD_W      = 2;
   localparam int X_W        = 10;
   localparam int Y_W        = 9;
   localparam int COLOR_W    = 8;
   localparam int IDX_W      = 18;
   localparam int CODE_W     = 3;
   localparam int BYTE_W     = 8;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 10;
   localparam int PROD_W     = Y_W + WIDTH_W;
   localparam int PIX_W      = PROD_W + 1;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 11;

   // register indexes and reset values
   localparam logic [CSR_ADDR_W-1:0] CSR_PANEL_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PANEL_HEIGHT = 1'b1;
   localparam logic [WIDTH_W-1:0]    WIDTH_RESET      = 11'd600;
   localparam logic [HEIGHT_W-1:0]   HEIGHT_RESET     = 10'd448;

   // quantizer thresholds
   localparam logic [COLOR_W-1:0] GRAY_SPREAD  = 8'd50;
   localparam logic [9:0]         LUMA_SPLIT   = 10'd382;
   localparam logic [COLOR_W-1:0] ON_LEVEL     = 8'd128;
   localparam logic [COLOR_W-1:0] YELLOW_LEVEL = 8'd170;
   localparam logic [COLOR_W-1:0] ORANGE_LEVEL = 8'd85;

   // palette codes
   localparam logic [CODE_W-1:0] CODE_BLACK  = 3'd0;
   localparam logic [CODE_W-1:0] CODE_WHITE  = 3'd1;
   localparam logic [CODE_W-1:0] CODE_GREEN  = 3'd2;
   localparam logic [CODE_W-1:0] CODE_BLUE   = 3'd3;
   localparam logic [CODE_W-1:0] CODE_RED    = 3'd4;
   localparam logic [CODE_W-1:0] CODE_YELLOW = 3'd5;
   localparam logic [CODE_W-1:0] CODE_ORANGE = 3'd6;

   // nibble masks
   localparam logic [BYTE_W-1:0] HIGH_NIBBLE = 8'hF0;
   localparam logic [BYTE_W-1:0] LOW_NIBBLE  = 8'h0F;

   typedef enum logic [CMD_W-1:0] {
      CMD_DRAW = 2'd0,
      CMD_FILL = 2'd1,
      CMD_READ = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_LOOKUP,
      ST_UPDATE,
      ST_FILL,
      ST_RESP
   } state_type;

endpackage

// ===== design/seven_color_framebuffer_writer.sv =====
// channel  | direction | payload
// req_     | in        | tuser cmd; tdata x, y, red, green, blue, byte_index
// rsp_     | out       | tuser dropped; tdata color_code, data_byte
// csr_     | in        | panel_width (index 0), panel_height (index 1)
//
// draw, read and no-op items pass through capture, quantize and row
// multiply, address and memory read, nibble update, result load.
// a fill sweeps every address through the single write port of the frame memory.
// reset clears control and the panel registers; the frame memory is undefined
// until filled or drawn, and there is no clearing pass.
// a stalled result holds in the output register; the next item is taken meanwhile.
module seven_color_framebuffer_writer #(
   parameter int STORE_BYTES = scfw_pkg::STORE_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // x_coord, y_coord, red, green, blue, byte_index, zero pad
   input  logic [scfw_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic [scfw_pkg::CMD_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // color_code, data_byte, zero pad
   output logic [scfw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // dropped
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [scfw_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [scfw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import scfw_pkg::*;

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam logic [31:0] STORE_LIMIT = 32'(STORE_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [X_W-1:0]      x_ff, x_in;
   logic [Y_W-1:0]      y_ff, y_in;
   logic [COLOR_W-1:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                low_nib_ff, low_nib_in;
   logic                drop_ff, drop_in;
   logic                hit_ff, hit_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   logic [ADDR_W-1:0]   fill_ptr_ff, fill_ptr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_drop_ff, rsp_drop_in;

   logic                req_accept;
   logic                out_free;
   logic                rsp_load;
   logic [CODE_W-1:0]   quant_code;
   logic [PIX_W-1:0]    pix;
   logic [31:0]         pix_byte;
   logic [31:0]         idx_wide;
   logic                in_panel;
   logic                draw_ok;
   logic                read_ok;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [BYTE_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [BYTE_W-1:0]   ram_rd_data;

   scfw_quantizer u_quant (
      .red        (red_ff),
      .green      (green_ff),
      .blue       (blue_ff),
      .color_code (quant_code)
   );

   scfw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // handshake terms
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == ST_RESP) && out_free;

   // address and range checks for the lookup step
   assign pix      = PIX_W'(x_ff) + PIX_W'(prod_ff);
   assign pix_byte = 32'(pix >> 1);
   assign idx_wide = 32'(idx_ff);
   assign in_panel = ({1'b0, x_ff} < width_ff) && ({1'b0, y_ff} < height_ff);
   assign draw_ok  = in_panel && (pix_byte < STORE_LIMIT);
   assign read_ok  = idx_wide < STORE_LIMIT;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_CALC;
         ST_CALC:   state_in = (cmd_ff == CMD_FILL) ? ST_FILL : ST_LOOKUP;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_RESP;
         ST_FILL:   if (fill_ptr_ff == LAST_ADDR) state_in = ST_RESP;
         ST_RESP:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // memory controls and ready
   always_comb begin
      req_tready  = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pix_byte[ADDR_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = low_nib_ff ? ((ram_rd_data & HIGH_NIBBLE) | BYTE_W'(code_ff))
                               : ((ram_rd_data & LOW_NIBBLE) | (BYTE_W'(code_ff) << 4));
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_LOOKUP: begin
            if (cmd_ff == CMD_DRAW) begin
               ram_rd_en = draw_ok;
            end else if (cmd_ff == CMD_READ) begin
               ram_rd_en   = read_ok;
               ram_rd_addr = idx_wide[ADDR_W-1:0];
            end
         end
         ST_UPDATE: begin
            ram_wr_en = (cmd_ff == CMD_DRAW) && !drop_ff;
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_ptr_ff;
            ram_wr_data = (BYTE_W'(code_ff) << 4) | BYTE_W'(code_ff);
         end
         default: begin
         end
      endcase
   end

   // item capture and datapath registers
   always_comb begin
      cmd_in      = cmd_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      blue_in     = blue_ff;
      idx_in      = idx_ff;
      code_in     = code_ff;
      prod_in     = prod_ff;
      addr_in     = addr_ff;
      low_nib_in  = low_nib_ff;
      drop_in     = drop_ff;
      hit_in      = hit_ff;
      data_in     = data_ff;
      fill_ptr_in = fill_ptr_ff;

      if (req_accept) begin
         cmd_in   = cmd_type'(req_tuser);
         x_in     = req_tdata[9:0];
         y_in     = req_tdata[18:10];
         red_in   = req_tdata[26:19];
         green_in = req_tdata[34:27];
         blue_in  = req_tdata[42:35];
         idx_in   = req_tdata[60:43];
      end

      case (state_ff)
         ST_CALC: begin
            code_in = quant_code;
            prod_in = PROD_W'(y_ff) * PROD_W'(width_ff);
            drop_in = 1'b0;
            data_in = '0;
         end
         ST_LOOKUP: begin
            addr_in    = pix_byte[ADDR_W-1:0];
            low_nib_in = pix[0];
            drop_in    = (cmd_ff == CMD_DRAW) && !draw_ok;
            hit_in     = read_ok;
         end
         ST_UPDATE: begin
            if (cmd_ff == CMD_READ && hit_ff) data_in = ram_rd_data;
         end
         ST_FILL: begin
            fill_ptr_in = (fill_ptr_ff == LAST_ADDR) ? '0 : fill_ptr_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // result register, parted from the input side
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_code_in  = rsp_code_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_drop_in  = rsp_drop_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = (cmd_ff == CMD_DRAW || cmd_ff == CMD_FILL) ? code_ff : CODE_BLACK;
         rsp_data_in  = data_ff;
         rsp_drop_in  = drop_ff;
      end
   end

   // panel registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_PANEL_WIDTH:  width_in  = csr_wdata;
            CSR_PANEL_HEIGHT: height_in = csr_wdata[HEIGHT_W-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         fill_ptr_ff  <= fill_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
      cmd_ff      <= cmd_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      idx_ff      <= idx_in;
      code_ff     <= code_in;
      prod_ff     <= prod_in;
      addr_ff     <= addr_in;
      low_nib_ff  <= low_nib_in;
      drop_ff     <= drop_in;
      hit_ff      <= hit_in;
      data_ff     <= data_in;
      rsp_code_ff <= rsp_code_in;
      rsp_data_ff <= rsp_data_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff, rsp_code_ff};
   assign rsp_tuser  = rsp_drop_ff;

endmodule

// ===== design/scfw_ram.sv =====
module scfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/scfw_quantizer.sv =====
module scfw_quantizer (
   input  logic [scfw_pkg::COLOR_W-1:0] red,
   input  logic [scfw_pkg::COLOR_W-1:0] green,
   input  logic [scfw_pkg::COLOR_W-1:0] blue,
   output logic [scfw_pkg::CODE_W-1:0]  color_code
);
   import scfw_pkg::*;

   logic [COLOR_W-1:0] hi;
   logic [COLOR_W-1:0] lo;
   logic [COLOR_W-1:0] spread;
   logic [9:0]         luma;
   logic               red_on;
   logic               green_on;
   logic               blue_on;

   // extremes and spread of the three components
   always_comb begin
      hi = red;
      lo = red;
      if (green > hi) hi = green;
      if (blue > hi)  hi = blue;
      if (green < lo) lo = green;
      if (blue < lo)  lo = blue;
      spread = hi - lo;
      luma = 10'(red) + 10'(green) + 10'(blue);
   end

   assign red_on   = red > ON_LEVEL;
   assign green_on = green > ON_LEVEL;
   assign blue_on  = blue > ON_LEVEL;

   // gray split by luminance, otherwise cube corner with red range split by green
   always_comb begin
      if (spread < GRAY_SPREAD) begin
         color_code = (luma > LUMA_SPLIT) ? CODE_WHITE : CODE_BLACK;
      end else if (red_on && !blue_on) begin
         if (green > YELLOW_LEVEL)      color_code = CODE_YELLOW;
         else if (green > ORANGE_LEVEL) color_code = CODE_ORANGE;
         else                           color_code = CODE_RED;
      end else if (!red_on && green_on) begin
         color_code = CODE_GREEN;
      end else if (!red_on && !green_on && blue_on) begin
         color_code = CODE_BLUE;
      end else if (red_on && !green_on) begin
         color_code = CODE_RED;
      end else if (red_on) begin
         color_code = CODE_WHITE;
      end else begin
         color_code = CODE_BLACK;
      end
   end

endmodule

// ===== design/scfw_checker.sv =====
module scfw_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [scfw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);
   import scfw_pkg::*;

   // nothing comes out in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // one item at a time: ready drops after a transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is at work");

   // a dropped draw never carries a stored byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[10:3] == 8'd0))
      else $error("dropped result with nonzero data byte");

   // palette code stays in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] != 3'd7))
      else $error("color code out of palette");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind seven_color_framebuffer_writer scfw_checker u_scfw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/seven_color_framebuffer_writer_test.sv =====
module seven_color_framebuffer_writer_test;
   import scfw_pkg::*;

   // one request as the sender sees it
   typedef struct {
      cmd_type              cmd;
      logic [X_W-1:0]       x;
      logic [Y_W-1:0]       y;
      logic [COLOR_W-1:0]   r;
      logic [COLOR_W-1:0]   g;
      logic [COLOR_W-1:0]   b;
      logic [IDX_W-1:0]     idx;
      bit                   drain;
   } pixel_req_type;

   // one response: palette code, stored byte, drop flag
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [BYTE_W-1:0] data;
      logic              dropped;
   } pixel_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // x_coord, y_coord, red, green, blue, byte_index, zero pad
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   // cmd
   logic [CMD_W-1:0]        req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // color_code, data_byte, zero pad
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   // dropped
   logic                    rsp_tuser;
   logic                    csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // shadow copy of the frame memory and the panel registers
   bit [BYTE_W-1:0] shadow_frame [STORE_BYTES_DEF];
   int              model_width = 600;
   int              model_height = 448;

   pixel_req_type  pending_q [$];
   pixel_rsp_type  expected_rsp_q [$];
   int             touched_q [$];
   pixel_req_type  in_flight;

   int        send_wait = 0;
   int        recv_wait = 0;
   int        error_count = 0;
   int        sent_count = 0;
   int        checked_count = 0;
   int        drop_count = 0;
   int        settings_count = 1;
   logic [9:0] tick = '0;
   wire       no_idle = (tick[9:8] == 2'b00);

   seven_color_framebuffer_writer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // free-running count; one quarter of the time both sides run without gaps
   always @(posedge clock) begin
      tick <= tick + 1'b1;
   end

   // rgb to seven-ink palette
   function automatic logic [CODE_W-1:0] palette_code(logic [COLOR_W-1:0] r,
                                                      logic [COLOR_W-1:0] g,
                                                      logic [COLOR_W-1:0] b);
      logic [COLOR_W-1:0] hi;
      logic [COLOR_W-1:0] lo;
      logic [9:0]         luma;
      logic               r_on;
      logic               g_on;
      logic               b_on;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      luma = 10'(r) + 10'(g) + 10'(b);
      // near gray splits on luminance
      if (hi - lo < GRAY_SPREAD) return (luma > LUMA_SPLIT) ? CODE_WHITE : CODE_BLACK;
      r_on = r > ON_LEVEL;
      g_on = g > ON_LEVEL;
      b_on = b > ON_LEVEL;
      // red without blue splits on green
      if (r_on && !b_on) begin
         if (g > YELLOW_LEVEL) return CODE_YELLOW;
         if (g > ORANGE_LEVEL) return CODE_ORANGE;
         return CODE_RED;
      end
      if (!r_on && g_on) return CODE_GREEN;
      if (!r_on && b_on) return CODE_BLUE;
      if (r_on && !g_on) return CODE_RED;
      if (r_on) return CODE_WHITE;
      return CODE_BLACK;
   endfunction

   // apply one request to the shadow frame and give its response
   function automatic pixel_rsp_type predict_framebuffer(pixel_req_type q);
      pixel_rsp_type rsp;
      int            pix;
      int            addr;
      rsp = '0;
      case (q.cmd)
         CMD_DRAW: begin
            rsp.code = palette_code(q.r, q.g, q.b);
            pix = int'(q.x) + int'(q.y) * model_width;
            addr = pix >> 1;
            if (int'(q.x) >= model_width || int'(q.y) >= model_height ||
                addr >= STORE_BYTES_DEF) begin
               rsp.dropped = 1'b1;
            end else if (pix[0]) begin
               shadow_frame[IDX_W'(addr)] = (shadow_frame[IDX_W'(addr)] & HIGH_NIBBLE) |
                                            {5'b0, rsp.code};
            end else begin
               shadow_frame[IDX_W'(addr)] = (shadow_frame[IDX_W'(addr)] & LOW_NIBBLE) |
                                            {1'b0, rsp.code, 4'b0};
            end
         end
         CMD_FILL: begin
            rsp.code = palette_code(q.r, q.g, q.b);
            for (int i = 0; i < STORE_BYTES_DEF; i++) begin
               shadow_frame[IDX_W'(i)] = {1'b0, rsp.code, 1'b0, rsp.code};
            end
         end
         CMD_READ: begin
            rsp.data = shadow_frame[q.idx];
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic void push_item(cmd_type c, int x, int y, int r, int g, int b,
                                     int idx, bit drain = 1'b0);
      pixel_req_type item;
      item.cmd = c;
      item.x = X_W'(x);
      item.y = Y_W'(y);
      item.r = COLOR_W'(r);
      item.g = COLOR_W'(g);
      item.b = COLOR_W'(b);
      item.idx = IDX_W'(idx);
      item.drain = drain;
      pending_q.push_back(item);
   endfunction

   // colors: uniform, near gray, or near the cube corners
   function automatic void pick_color(output int r, output int g, output int b);
      int mode;
      int base;
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
         r = $urandom_range(0, 255);
         g = $urandom_range(0, 255);
         b = $urandom_range(0, 255);
      end else if (mode < 80) begin
         base = $urandom_range(24, 231);
         r = base + int'($urandom_range(0, 48)) - 24;
         g = base + int'($urandom_range(0, 48)) - 24;
         b = base + int'($urandom_range(0, 48)) - 24;
      end else begin
         r = $urandom_range(0, 1) ? $urandom_range(200, 255) : $urandom_range(0, 60);
         g = $urandom_range(0, 1) ? $urandom_range(200, 255) : $urandom_range(0, 60);
         b = $urandom_range(0, 1) ? $urandom_range(200, 255) : $urandom_range(0, 60);
      end
   endfunction

   // mostly in-panel draws with read-back of drawn bytes, plus noise
   function automatic void queue_random_items(int count, bit with_fill);
      int      roll;
      int      x;
      int      y;
      int      r;
      int      g;
      int      b;
      int      idx;
      int      addr;
      cmd_type c;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         pick_color(r, g, b);
         x = $urandom_range(0, 1023);
         y = $urandom_range(0, 511);
         idx = $urandom_range(0, STORE_BYTES_DEF - 1);
         c = CMD_DRAW;
         if (with_fill && i == count / 3) begin
            c = CMD_FILL;
         end else if (roll < 60) begin
            if (model_width > 0 && model_height > 0) begin
               x = $urandom_range(0, (model_width > 1024 ? 1024 : model_width) - 1);
               y = $urandom_range(0, (model_height > 512 ? 512 : model_height) - 1);
               addr = (x + y * model_width) >> 1;
               if (addr < STORE_BYTES_DEF) touched_q.push_back(addr);
               if (touched_q.size() > 64) void'(touched_q.pop_front());
            end
         end else if (roll < 72) begin
            c = CMD_DRAW;
         end else if (roll < 95) begin
            c = CMD_READ;
            if (roll < 86 && touched_q.size() != 0) begin
               idx = touched_q[$urandom_range(0, touched_q.size() - 1)];
            end
         end else begin
            c = CMD_NOP;
         end
         push_item(c, x, y, r, g, b, idx, i == count / 2);
      end
   endfunction

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_panel(int w, int h);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= CSR_PANEL_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_addr <= CSR_PANEL_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_we <= 1'b0;
      model_width = w;
      model_height = h;
      settings_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp_q.push_back(predict_framebuffer(in_flight));
            sent_count++;
         end
         if (req_tvalid && !req_tready) begin
            // hold the transfer until taken
         end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            req_tvalid <= 1'b0;
         end else if (pending_q.size() != 0 &&
                      !(pending_q[0].drain && expected_rsp_q.size() != 0)) begin
            in_flight = pending_q.pop_front();
            req_tdata <= {3'b0, in_flight.idx, in_flight.b, in_flight.g, in_flight.r,
                          in_flight.y, in_flight.x};
            req_tuser <= in_flight.cmd;
            req_tvalid <= 1'b1;
            send_wait <= no_idle ? 0 : $urandom_range(0, 9);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : rsp_side
      int            stall;
      pixel_rsp_type want;
      pixel_rsp_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[CODE_W-1:0], rsp_tdata[CODE_W+BYTE_W-1:CODE_W], rsp_tuser};
         if (expected_rsp_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transfer: code %0d byte %02h dropped %0b",
                     $time, got.code, got.data, got.dropped);
         end else begin
            want = expected_rsp_q.pop_front();
            checked_count++;
            if (got.dropped) drop_count++;
            if (got.code !== want.code) begin
               error_count++;
               $display("%0t: color_code expected %0d actual %0d", $time, want.code, got.code);
            end
            if (got.data !== want.data) begin
               error_count++;
               $display("%0t: data_byte expected %02h actual %02h", $time, want.data, got.data);
            end
            if (got.dropped !== want.dropped) begin
               error_count++;
               $display("%0t: dropped expected %0b actual %0b", $time, want.dropped,
                        got.dropped);
            end
         end
         stall = no_idle ? 0 : $urandom_range(0, 9);
         recv_wait <= stall;
         rsp_tready <= (stall == 0);
      end else if (recv_wait > 0) begin
         recv_wait <= recv_wait - 1;
         rsp_tready <= (recv_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // stimulus sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: fill first so every byte is defined, then palette edges
      push_item(CMD_FILL, 0, 0, 255, 128, 0, 0);
      push_item(CMD_DRAW, 0, 0, 0, 0, 0, 0);
      push_item(CMD_DRAW, 1, 0, 255, 255, 255, 0);
      push_item(CMD_READ, 0, 0, 0, 0, 0, 0, 1'b1);
      push_item(CMD_DRAW, 599, 447, 0, 255, 0, 0);
      push_item(CMD_DRAW, 598, 447, 0, 0, 255, 0);
      push_item(CMD_READ, 0, 0, 0, 0, 0, 134399);
      // outside the panel: x edge, y edge, every coordinate bit set
      push_item(CMD_DRAW, 600, 0, 255, 0, 0, 0);
      push_item(CMD_DRAW, 0, 448, 255, 0, 0, 0);
      push_item(CMD_DRAW, 1023, 511, 255, 255, 0, 0);
      // cyan maps to green, magenta to red
      push_item(CMD_DRAW, 2, 0, 0, 255, 255, 0);
      push_item(CMD_DRAW, 3, 0, 255, 0, 255, 0);
      push_item(CMD_READ, 0, 0, 0, 0, 0, 1);
      // orange and yellow green thresholds
      push_item(CMD_DRAW, 4, 0, 255, 86, 0, 0);
      push_item(CMD_DRAW, 5, 0, 255, 85, 0, 0);
      push_item(CMD_DRAW, 6, 0, 255, 171, 0, 0);
      push_item(CMD_DRAW, 7, 0, 255, 170, 0, 0);
      // luminance split and gray spread limit
      push_item(CMD_DRAW, 8, 0, 127, 127, 128, 0);
      push_item(CMD_DRAW, 9, 0, 127, 128, 128, 0);
      push_item(CMD_DRAW, 12, 0, 129, 100, 80, 0);
      push_item(CMD_DRAW, 13, 0, 129, 100, 79, 0);
      // red on level
      push_item(CMD_DRAW, 14, 0, 128, 0, 255, 0);
      push_item(CMD_DRAW, 15, 0, 129, 0, 255, 0);
      push_item(CMD_READ, 0, 0, 0, 0, 0, 2);
      push_item(CMD_READ, 0, 0, 0, 0, 0, 6);
      push_item(CMD_READ, 0, 0, 0, 0, 0, 7);
      push_item(CMD_NOP, 1023, 511, 255, 255, 255, 262143);
      push_item(CMD_READ, 0, 0, 0, 0, 0, 262143);

      // random phases over several panel settings
      queue_random_items(155, 1'b0);
      wait_drained();
      set_panel(1024, 512);
      queue_random_items(155, 1'b0);
      wait_drained();
      set_panel(1, 1);
      queue_random_items(155, 1'b0);
      wait_drained();
      set_panel(0, 0);
      queue_random_items(155, 1'b0);
      wait_drained();
      set_panel(2047, 1023);
      queue_random_items(155, 1'b1);
      wait_drained();
      set_panel(1023, 511);
      queue_random_items(155, 1'b0);
      wait_drained();
      set_panel($urandom_range(2, 1024), $urandom_range(2, 512));
      queue_random_items(155, 1'b0);

      wait_drained();
      repeat (10) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
      end
      $display("sent %0d requests over %0d panel settings with two full fills",
               sent_count, settings_count);
      $display("checked %0d responses, %0d of them dropped draws", checked_count,
               drop_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #30000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
